@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the timer queue rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define STQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition must never be seen out of reset
`define STQ_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

@@ hw/rtl/stq_pkg.sv @@
// stq_pkg: widths, codes and helpers of the sorted timer queue
// no dependencies; used by the interfaces, controller, memories and top level
package stq_pkg;

	localparam int KIND_W       = 2;
	localparam int DELAY_W      = 32;
	localparam int SLOT_W       = 6;
	localparam int EVENT_W      = 3;
	localparam int IDX_OUT_W    = 6;
	localparam int TIME_W       = 48;
	localparam int CAPACITY_DEF = 16;
	localparam int MAX_RESULTS  = 16;

	typedef logic [TIME_W-1:0] time_t;

	localparam time_t TIME_MAX = {TIME_W{1'b1}};

	localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

	localparam logic [EVENT_W-1:0] EV_ADDED      = 3'd0;
	localparam logic [EVENT_W-1:0] EV_FULL       = 3'd1;
	localparam logic [EVENT_W-1:0] EV_DELETED    = 3'd2;
	localparam logic [EVENT_W-1:0] EV_BAD_INDEX  = 3'd3;
	localparam logic [EVENT_W-1:0] EV_FIRED      = 3'd4;
	localparam logic [EVENT_W-1:0] EV_NONE_FIRED = 3'd5;

	// saturating deadline sum
	function automatic time_t sat_add(input time_t a, input logic [DELAY_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W-DELAY_W+1){1'b0}}, b};
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

endpackage

@@ hw/rtl/stq_if.sv @@
// stq_in_if, stq_out_if: valid/ready channels of the timer queue
// depends on stq_pkg for field widths
interface stq_in_if;
	import stq_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [DELAY_W-1:0] delay;
	logic [DELAY_W-1:0] period;
	logic [SLOT_W-1:0]  slot;

	modport source (output valid, kind, delay, period, slot, input ready);
	modport sink   (input valid, kind, delay, period, slot, output ready);
endinterface

interface stq_out_if;
	import stq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [EVENT_W-1:0]   event_res;
	logic [IDX_OUT_W-1:0] timer_index;
	logic                 last;

	modport source (output valid, event_res, timer_index, last, input ready);
	modport sink   (input valid, event_res, timer_index, last, output ready);
endinterface

@@ hw/rtl/sorted_timer_queue_unit.sv @@
// sorted_timer_queue_unit: timer queue with a deadline-sorted slot list
// top level; depends on stq_pkg, stq_if, stq_mem and stq_ctrl
//
// req carries one item per transfer: add (delay, period), delete (slot) or a
// one millisecond tick. rsp returns event_res and timer_index per result, with
// last set on the final result of each item; a tick returns one result per
// fired timer (at most 16) or a single "none fired" result.
// req is taken one item at a time, only while the sequencer is idle.
// A delete pushes its result directly; an add takes a slot off the free list,
// walks the list to its sorted place and writes the links; a tick pops each
// expired entry off the head and frees it, or walks it back into place if it re-arms.
// The list walk does one link memory read per cycle.
// Results leave through a single output register: while rsp is stalled the
// sequencer holds at its next result and the output keeps its values.
// Reset (arst_n low) empties the list, frees every slot and clears the time;
// no clearing pass is needed before the block takes items.
module sorted_timer_queue_unit #(
	parameter int CAPACITY = stq_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	stq_in_if.sink    req,
	stq_out_if.source rsp
);
	import stq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int LW = IW + 1;

	logic               tm_rd_en, tm_wr_en, lk_rd_en, lk_wr_en;
	logic [IW-1:0]      tm_rd_addr, tm_wr_addr, lk_rd_addr, lk_wr_addr;
	time_t              tm_rd_dl, tm_wr_dl;
	logic [DELAY_W-1:0] tm_rd_iv, tm_wr_iv;
	logic [LW-1:0]      lk_rd_data, lk_wr_data;

	stq_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.tm_rd_en   (tm_rd_en),
		.tm_rd_addr (tm_rd_addr),
		.tm_rd_dl   (tm_rd_dl),
		.tm_rd_iv   (tm_rd_iv),
		.tm_wr_en   (tm_wr_en),
		.tm_wr_addr (tm_wr_addr),
		.tm_wr_dl   (tm_wr_dl),
		.tm_wr_iv   (tm_wr_iv),
		.lk_rd_en   (lk_rd_en),
		.lk_rd_addr (lk_rd_addr),
		.lk_rd_data (lk_rd_data),
		.lk_wr_en   (lk_wr_en),
		.lk_wr_addr (lk_wr_addr),
		.lk_wr_data (lk_wr_data)
	);

	stq_mem #(
		.CAPACITY (CAPACITY)
	) u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.tm_rd_en   (tm_rd_en),
		.tm_rd_addr (tm_rd_addr),
		.tm_rd_dl   (tm_rd_dl),
		.tm_rd_iv   (tm_rd_iv),
		.tm_wr_en   (tm_wr_en),
		.tm_wr_addr (tm_wr_addr),
		.tm_wr_dl   (tm_wr_dl),
		.tm_wr_iv   (tm_wr_iv),
		.lk_rd_en   (lk_rd_en),
		.lk_rd_addr (lk_rd_addr),
		.lk_rd_data (lk_rd_data),
		.lk_wr_en   (lk_wr_en),
		.lk_wr_addr (lk_wr_addr),
		.lk_wr_data (lk_wr_data)
	);

endmodule

@@ hw/rtl/stq_mem.sv @@
// stq_mem: timer memory (deadline, interval) and link memory of the queue
// one read and one write port each, registered read data; depends on stq_pkg
module stq_mem #(
	parameter int CAPACITY = stq_pkg::CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tm_rd_en,
	input  logic [$clog2(CAPACITY)-1:0] tm_rd_addr,
	output stq_pkg::time_t             tm_rd_dl,
	output logic [stq_pkg::DELAY_W-1:0] tm_rd_iv,
	input  logic                       tm_wr_en,
	input  logic [$clog2(CAPACITY)-1:0] tm_wr_addr,
	input  stq_pkg::time_t             tm_wr_dl,
	input  logic [stq_pkg::DELAY_W-1:0] tm_wr_iv,
	input  logic                       lk_rd_en,
	input  logic [$clog2(CAPACITY)-1:0] lk_rd_addr,
	output logic [$clog2(CAPACITY):0]  lk_rd_data,
	input  logic                       lk_wr_en,
	input  logic [$clog2(CAPACITY)-1:0] lk_wr_addr,
	input  logic [$clog2(CAPACITY):0]  lk_wr_data
);
	import stq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int LW = IW + 1;
	localparam int TW = TIME_W + DELAY_W;
	localparam logic [LW-1:0] LINK_NIL = {LW{1'b1}};

	logic [TW-1:0] tm_mem [CAPACITY];
	logic [TW-1:0] tm_rd_q;
	logic [LW-1:0] lk_mem [CAPACITY];
	logic [LW-1:0] lk_rd_q;
	logic [IW-1:0] lk_rd_addr_q;
	logic          lk_rd_vld_q;
	logic [CAPACITY-1:0] lk_vld_q;

	// link value of an entry never written since reset
	function automatic logic [LW-1:0] link_reset(input logic [IW-1:0] a);
		logic [LW-1:0] nx;
		nx = {1'b0, a} + LW'(1);
		return (nx < LW'(CAPACITY)) ? nx : LINK_NIL;
	endfunction

	always_ff @(posedge clk) begin
		if (tm_wr_en) begin
			tm_mem[tm_wr_addr] <= {tm_wr_dl, tm_wr_iv};
		end
		if (tm_rd_en) begin
			tm_rd_q <= tm_mem[tm_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (lk_wr_en) begin
			lk_mem[lk_wr_addr] <= lk_wr_data;
		end
		if (lk_rd_en) begin
			lk_rd_q      <= lk_mem[lk_rd_addr];
			lk_rd_addr_q <= lk_rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_vld_q    <= '0;
			lk_rd_vld_q <= 1'b0;
		end else begin
			if (lk_wr_en) begin
				lk_vld_q[lk_wr_addr] <= 1'b1;
			end
			if (lk_rd_en) begin
				lk_rd_vld_q <= lk_vld_q[lk_rd_addr];
			end
		end
	end

	assign tm_rd_dl   = tm_rd_q[TW-1:DELAY_W];
	assign tm_rd_iv   = tm_rd_q[DELAY_W-1:0];
	assign lk_rd_data = lk_rd_vld_q ? lk_rd_q : link_reset(lk_rd_addr_q);

endmodule

@@ hw/rtl/stq_ctrl.sv @@
// stq_ctrl: sequencer of the timer queue; list walks, free list, output register
// depends on stq_pkg, stq_if and assert_macros.svh; drives the ports of stq_mem
`include "assert_macros.svh"

module stq_ctrl #(
	parameter int CAPACITY = stq_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	stq_in_if.sink                      req,
	stq_out_if.source                   rsp,
	output logic                        tm_rd_en,
	output logic [$clog2(CAPACITY)-1:0] tm_rd_addr,
	input  stq_pkg::time_t              tm_rd_dl,
	input  logic [stq_pkg::DELAY_W-1:0] tm_rd_iv,
	output logic                        tm_wr_en,
	output logic [$clog2(CAPACITY)-1:0] tm_wr_addr,
	output stq_pkg::time_t              tm_wr_dl,
	output logic [stq_pkg::DELAY_W-1:0] tm_wr_iv,
	output logic                        lk_rd_en,
	output logic [$clog2(CAPACITY)-1:0] lk_rd_addr,
	input  logic [$clog2(CAPACITY):0]   lk_rd_data,
	output logic                        lk_wr_en,
	output logic [$clog2(CAPACITY)-1:0] lk_wr_addr,
	output logic [$clog2(CAPACITY):0]   lk_wr_data
);
	import stq_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int LW = IW + 1;
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);
	localparam logic [LW-1:0] LINK_NIL = {LW{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE, S_A_LINK, S_W_START, S_W_EV, S_W_LNK1, S_W_LNK2, S_W_DONE,
		S_T_RD, S_T_EV, S_T_END, S_PUSH
	} state_t;

	state_t               state_q, ret_q;
	time_t                now_q, ins_dl_q;
	logic [LW-1:0]        act_head_q, free_head_q, cur_q, prev_q, guard_q;
	logic [OW-1:0]        occ_q;
	logic [CAPACITY-1:0]  live_q;
	logic                 op_tick_q;
	logic [IW-1:0]        idx_q, pend_idx_q;
	logic [NW-1:0]        n_q;
	logic                 pend_vld_q;
	logic [EVENT_W-1:0]   psh_ev_q, out_ev_q;
	logic [IDX_OUT_W-1:0] psh_idx_q, out_idx_q;
	logic                 psh_last_q, out_last_q, out_vld_q;

	logic          out_free;
	logic [IW-1:0] free_idx, h_idx;
	logic          h_live, t_exp, t_release, t_rearm, step_go, step_more;
	logic [LW-1:0] guard_nx;
	time_t         add_dl, rearm_dl;

	assign out_free  = !out_vld_q || rsp.ready;
	assign free_idx  = free_head_q[IW-1:0];
	assign h_idx     = act_head_q[IW-1:0];
	assign h_live    = live_q[h_idx];
	assign t_exp     = tm_rd_dl <= now_q;
	assign t_release = t_exp && (!h_live || tm_rd_iv == '0);
	assign t_rearm   = t_exp && h_live && tm_rd_iv != '0;
	assign add_dl    = sat_add(now_q, req.delay);
	assign rearm_dl  = sat_add(tm_rd_dl, tm_rd_iv);
	assign guard_nx  = guard_q + LW'(1);
	assign step_go   = tm_rd_dl <= ins_dl_q;
	assign step_more = !lk_rd_data[LW-1] && (guard_nx < LW'(CAPACITY));

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_vld_q;
	assign rsp.event_res   = out_ev_q;
	assign rsp.timer_index = out_idx_q;
	assign rsp.last        = out_last_q;

	// memory port control
	always_comb begin
		tm_rd_en   = 1'b0;
		tm_rd_addr = h_idx;
		tm_wr_en   = 1'b0;
		tm_wr_addr = h_idx;
		tm_wr_dl   = rearm_dl;
		tm_wr_iv   = tm_rd_iv;
		lk_rd_en   = 1'b0;
		lk_rd_addr = h_idx;
		lk_wr_en   = 1'b0;
		lk_wr_addr = h_idx;
		lk_wr_data = free_head_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.kind == KIND_ADD && !free_head_q[LW-1]) begin
					lk_rd_en   = 1'b1;
					lk_rd_addr = free_idx;
					tm_wr_en   = 1'b1;
					tm_wr_addr = free_idx;
					tm_wr_dl   = add_dl;
					tm_wr_iv   = req.period;
				end
			end
			S_W_START: begin
				tm_rd_en = !act_head_q[LW-1];
				lk_rd_en = !act_head_q[LW-1];
			end
			S_W_EV: begin
				tm_rd_addr = lk_rd_data[IW-1:0];
				lk_rd_addr = lk_rd_data[IW-1:0];
				tm_rd_en   = step_go && step_more;
				lk_rd_en   = step_go && step_more;
			end
			S_W_LNK1: begin
				lk_wr_en   = 1'b1;
				lk_wr_addr = idx_q;
				lk_wr_data = prev_q[LW-1] ? act_head_q : cur_q;
			end
			S_W_LNK2: begin
				lk_wr_en   = 1'b1;
				lk_wr_addr = prev_q[IW-1:0];
				lk_wr_data = {1'b0, idx_q};
			end
			S_T_RD: begin
				tm_rd_en = !act_head_q[LW-1] && (n_q < NW'(MAX_RESULTS));
				lk_rd_en = !act_head_q[LW-1] && (n_q < NW'(MAX_RESULTS));
			end
			S_T_EV: begin
				lk_wr_en = t_release;
				tm_wr_en = t_rearm;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			now_q       <= '0;
			ins_dl_q    <= '0;
			act_head_q  <= LINK_NIL;
			free_head_q <= '0;
			cur_q       <= LINK_NIL;
			prev_q      <= LINK_NIL;
			guard_q     <= '0;
			occ_q       <= '0;
			live_q      <= '0;
			op_tick_q   <= 1'b0;
			idx_q       <= '0;
			pend_idx_q  <= '0;
			n_q         <= '0;
			pend_vld_q  <= 1'b0;
			psh_ev_q    <= EV_NONE_FIRED;
			psh_idx_q   <= '0;
			psh_last_q  <= 1'b0;
			out_vld_q   <= 1'b0;
			out_ev_q    <= EV_NONE_FIRED;
			out_idx_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_vld_q && rsp.ready && state_q != S_PUSH) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						case (req.kind)
							KIND_ADD: begin
								if (free_head_q[LW-1]) begin
									psh_ev_q   <= EV_FULL;
									psh_idx_q  <= '0;
									psh_last_q <= 1'b1;
									ret_q      <= S_IDLE;
									state_q    <= S_PUSH;
								end else begin
									idx_q            <= free_idx;
									ins_dl_q         <= add_dl;
									live_q[free_idx] <= 1'b1;
									op_tick_q        <= 1'b0;
									state_q          <= S_A_LINK;
								end
							end
							KIND_DEL: begin
								if ({1'b0, req.slot} >= (SLOT_W+1)'(CAPACITY)) begin
									psh_ev_q <= EV_BAD_INDEX;
								end else begin
									live_q[req.slot[IW-1:0]] <= 1'b0;
									psh_ev_q                 <= EV_DELETED;
								end
								psh_idx_q  <= req.slot;
								psh_last_q <= 1'b1;
								ret_q      <= S_IDLE;
								state_q    <= S_PUSH;
							end
							KIND_TICK: begin
								if (now_q != TIME_MAX) begin
									now_q <= now_q + TIME_W'(1);
								end
								n_q        <= '0;
								pend_vld_q <= 1'b0;
								op_tick_q  <= 1'b1;
								state_q    <= S_T_RD;
							end
							default: begin
							end
						endcase
					end
				end
				S_A_LINK: begin
					free_head_q <= lk_rd_data;
					state_q     <= S_W_START;
				end
				S_W_START: begin
					prev_q  <= LINK_NIL;
					cur_q   <= act_head_q;
					guard_q <= '0;
					state_q <= act_head_q[LW-1] ? S_W_LNK1 : S_W_EV;
				end
				S_W_EV: begin
					if (step_go) begin
						prev_q  <= cur_q;
						cur_q   <= lk_rd_data;
						guard_q <= guard_nx;
						if (!step_more) begin
							state_q <= S_W_LNK1;
						end
					end else begin
						state_q <= S_W_LNK1;
					end
				end
				S_W_LNK1: begin
					if (prev_q[LW-1]) begin
						act_head_q <= {1'b0, idx_q};
						state_q    <= S_W_DONE;
					end else begin
						state_q <= S_W_LNK2;
					end
				end
				S_W_LNK2: begin
					state_q <= S_W_DONE;
				end
				S_W_DONE: begin
					if (op_tick_q) begin
						state_q <= S_T_RD;
					end else begin
						occ_q      <= occ_q + OW'(1);
						psh_ev_q   <= EV_ADDED;
						psh_idx_q  <= IDX_OUT_W'(idx_q);
						psh_last_q <= 1'b1;
						ret_q      <= S_IDLE;
						state_q    <= S_PUSH;
					end
				end
				S_T_RD: begin
					if (!act_head_q[LW-1] && (n_q < NW'(MAX_RESULTS))) begin
						state_q <= S_T_EV;
					end else begin
						state_q <= S_T_END;
					end
				end
				S_T_EV: begin
					if (t_exp) begin
						act_head_q <= lk_rd_data;
						idx_q      <= h_idx;
						if (t_release) begin
							live_q[h_idx] <= 1'b0;
							free_head_q   <= {1'b0, h_idx};
							if (occ_q != '0) begin
								occ_q <= occ_q - OW'(1);
							end
						end
						if (t_rearm) begin
							ins_dl_q <= rearm_dl;
						end
						if (!h_live) begin
							state_q <= S_T_RD;
						end else begin
							n_q        <= n_q + NW'(1);
							pend_vld_q <= 1'b1;
							pend_idx_q <= h_idx;
							if (pend_vld_q) begin
								psh_ev_q   <= EV_FIRED;
								psh_idx_q  <= IDX_OUT_W'(pend_idx_q);
								psh_last_q <= 1'b0;
								ret_q      <= t_rearm ? S_W_START : S_T_RD;
								state_q    <= S_PUSH;
							end else begin
								state_q <= t_rearm ? S_W_START : S_T_RD;
							end
						end
					end else begin
						state_q <= S_T_END;
					end
				end
				S_T_END: begin
					if (pend_vld_q) begin
						psh_ev_q  <= EV_FIRED;
						psh_idx_q <= IDX_OUT_W'(pend_idx_q);
					end else begin
						psh_ev_q  <= EV_NONE_FIRED;
						psh_idx_q <= '0;
					end
					psh_last_q <= 1'b1;
					ret_q      <= S_IDLE;
					state_q    <= S_PUSH;
				end
				S_PUSH: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_ev_q   <= psh_ev_q;
						out_idx_q  <= psh_idx_q;
						out_last_q <= psh_last_q;
						state_q    <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`STQ_ASSERT(a_occ_free, (state_q == S_IDLE) |-> (free_head_q[LW-1] == (occ_q == OW'(CAPACITY))), "free list and occupancy disagree")
	`STQ_ASSERT(a_rsp_hold, (out_vld_q && !rsp.ready) |=> (out_vld_q && $stable(out_ev_q) && $stable(out_idx_q) && $stable(out_last_q)), "result changed while stalled")
	`STQ_ASSERT_NEVER(a_fire_bound, (n_q > NW'(MAX_RESULTS)) || (pend_vld_q && n_q == '0), "fire count out of range")

endmodule

@@ dv/sorted_timer_queue_unit_test.sv @@
// sorted_timer_queue_unit_test: self-checking bench of the sorted timer queue
// a scoreboard class predicts add, delete and tick results; tasks drive req and an always block drives rsp
// depends on stq_pkg, stq_if and sorted_timer_queue_unit
module sorted_timer_queue_unit_test;
	import stq_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int NONE = -1;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
	localparam int RANDOM_ITEMS = 450;

	class stq_scoreboard;
		typedef struct packed {
			logic [EVENT_W-1:0]   event_res;
			logic [IDX_OUT_W-1:0] timer_index;
			logic                 last;
		} timer_result_t;

		timer_result_t      expected_events[$];
		time_t              now_ms;
		time_t              due[CAP];
		logic [DELAY_W-1:0] every[CAP];
		int                 next_of[CAP];
		bit                 armed[CAP];
		int                 head;
		int                 free_head;
		int                 errors;
		int                 checked;
		int                 adds;
		int                 dels;
		int                 ticks;
		int                 ignored;
		int                 fires;
		int                 refusals;

		function new();
			now_ms = '0;
			for (int i = 0; i < CAP; i++) begin
				due[i] = '0;
				every[i] = '0;
				armed[i] = 1'b0;
				next_of[i] = (i + 1 < CAP) ? i + 1 : NONE;
			end
			head = NONE;
			free_head = 0;
		endfunction

		function void report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endfunction

		function timer_result_t result_of(logic [EVENT_W-1:0] ev, int idx);
			timer_result_t r;
			r.event_res = ev;
			r.timer_index = idx[IDX_OUT_W-1:0];
			r.last = 1'b0;
			return r;
		endfunction

		function time_t sum_capped(time_t a, logic [DELAY_W-1:0] b);
			time_t wide_b;
			wide_b = {{(TIME_W-DELAY_W){1'b0}}, b};
			if (a > TIME_MAX - wide_b)
				return TIME_MAX;
			return a + wide_b;
		endfunction

		// sorted insert, after every entry with an equal or earlier deadline
		function void place(int s);
			int prev;
			int cur;
			int steps;
			prev = NONE;
			cur = head;
			steps = 0;
			while (cur != NONE && steps < CAP && due[cur] <= due[s]) begin
				prev = cur;
				cur = next_of[cur];
				steps++;
			end
			if (prev == NONE) begin
				next_of[s] = head;
				head = s;
			end else begin
				next_of[s] = cur;
				next_of[prev] = s;
			end
		endfunction

		function void free_slot(int s);
			armed[s] = 1'b0;
			next_of[s] = free_head;
			free_head = s;
		endfunction

		function void note_item(logic [KIND_W-1:0] kind, logic [DELAY_W-1:0] delay,
				logic [DELAY_W-1:0] period, logic [SLOT_W-1:0] slot);
			timer_result_t outs[$];
			int s;
			case (kind)
			KIND_ADD: begin
				adds++;
				if (free_head == NONE) begin
					outs.push_back(result_of(EV_FULL, 0));
					refusals++;
				end else begin
					s = free_head;
					free_head = next_of[s];
					due[s] = sum_capped(now_ms, delay);
					every[s] = period;
					armed[s] = 1'b1;
					place(s);
					outs.push_back(result_of(EV_ADDED, s));
				end
			end
			KIND_DEL: begin
				dels++;
				if (int'(slot) >= CAP) begin
					outs.push_back(result_of(EV_BAD_INDEX, int'(slot)));
				end else begin
					armed[slot] = 1'b0;
					outs.push_back(result_of(EV_DELETED, int'(slot)));
				end
			end
			KIND_TICK: begin
				ticks++;
				if (now_ms != TIME_MAX)
					now_ms++;
				while (head != NONE && outs.size() < MAX_RESULTS && due[head] <= now_ms) begin
					s = head;
					head = next_of[s];
					if (!armed[s]) begin
						free_slot(s);
					end else begin
						outs.push_back(result_of(EV_FIRED, s));
						fires++;
						if (every[s] != '0) begin
							due[s] = sum_capped(due[s], every[s]);
							place(s);
						end else begin
							free_slot(s);
						end
					end
				end
				if (outs.size() == 0)
					outs.push_back(result_of(EV_NONE_FIRED, 0));
			end
			default: begin
				ignored++;
			end
			endcase
			if (outs.size() > 0) begin
				outs[outs.size() - 1].last = 1'b1;
				foreach (outs[i])
					expected_events.push_back(outs[i]);
			end
		endfunction

		function void check_event(logic [EVENT_W-1:0] ev, logic [IDX_OUT_W-1:0] idx,
				logic last_bit);
			timer_result_t want;
			if (expected_events.size() == 0) begin
				report($sformatf("result with nothing expected: event %0d index %0d", ev, idx));
				return;
			end
			want = expected_events.pop_front();
			checked++;
			if (ev !== want.event_res)
				report($sformatf("event_res %0d, expected %0d", ev, want.event_res));
			if (idx !== want.timer_index)
				report($sformatf("timer_index %0d, expected %0d", idx, want.timer_index));
			if (last_bit !== want.last)
				report($sformatf("last %0b, expected %0b", last_bit, want.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit steady;
	int hold_left;
	stq_scoreboard board;

	stq_in_if  req();
	stq_out_if rsp();

	sorted_timer_queue_unit #(
		.CAPACITY(CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(9, 30);
	endfunction

	task automatic push_item(logic [KIND_W-1:0] kind, logic [DELAY_W-1:0] delay,
			logic [DELAY_W-1:0] period, logic [SLOT_W-1:0] slot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid  <= 1'b1;
		req.kind   <= kind;
		req.delay  <= delay;
		req.period <= period;
		req.slot   <= slot;
		do
			@(posedge clk);
		while (!req.ready);
		board.note_item(kind, delay, period, slot);
	endtask

	task automatic random_item(output bit counted);
		int pick;
		logic [KIND_W-1:0] kind;
		logic [DELAY_W-1:0] delay;
		logic [DELAY_W-1:0] period;
		logic [SLOT_W-1:0] slot;
		pick = $urandom_range(0, 99);
		kind = (pick < 36) ? KIND_ADD : (pick < 60) ? KIND_DEL :
			(pick < 98) ? KIND_TICK : KIND_IGNORED;
		pick = $urandom_range(0, 99);
		delay = (pick < 60) ? $urandom_range(0, 15) :
			(pick < 99) ? $urandom_range(0, 150) : $urandom();
		pick = $urandom_range(0, 99);
		period = (pick < 45) ? 32'd0 : (pick < 85) ? $urandom_range(1, 25) :
			(pick < 99) ? $urandom_range(26, 400) : $urandom();
		slot = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, CAP - 1)) :
			SLOT_W'($urandom_range(0, 63));
		push_item(kind, delay, period, slot);
		counted = (kind != KIND_IGNORED);
	endtask

	task automatic directed_items();
		push_item(KIND_TICK, 32'd0, 32'd0, 6'd0);
		push_item(KIND_ADD, 32'd0, 32'd0, 6'd0);
		push_item(KIND_ADD, 32'hFFFF_FFFF, 32'd0, 6'd0);
		push_item(KIND_ADD, 32'd2, 32'hFFFF_FFFF, 6'd0);
		push_item(KIND_ADD, 32'd2, 32'd0, 6'd0);
		push_item(KIND_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
		push_item(KIND_TICK, 32'd0, 32'd0, 6'd0);
		push_item(KIND_DEL, 32'd0, 32'd0, 6'd63);
		push_item(KIND_DEL, 32'd0, 32'd0, 6'd15);
		push_item(KIND_DEL, 32'd0, 32'd0, 6'd3);
		push_item(KIND_DEL, 32'd0, 32'd0, 6'd3);
		push_item(KIND_TICK, 32'd0, 32'd0, 6'd0);
		// fill the queue with timers all due now, three of them repeating every tick; one more add then finds it full
		for (int i = 0; i < 11; i++)
			push_item(KIND_ADD, 32'd0, 32'd0, 6'd0);
		for (int i = 0; i < 3; i++)
			push_item(KIND_ADD, 32'd0, 32'd1, 6'd0);
		push_item(KIND_ADD, 32'd1, 32'd1, 6'd0);
		push_item(KIND_TICK, 32'd0, 32'd0, 6'd0);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_event(rsp.event_res, rsp.timer_index, rsp.last);
		if (hold_left == 0 && !steady && $urandom_range(0, 3) == 0)
			hold_left = pick_gap();
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		int done;
		bit counted;
		board = new();
		arst_n = 1'b0;
		steady = 1'b0;
		hold_left = 0;
		req.valid = 1'b0;
		req.kind = KIND_ADD;
		req.delay = '0;
		req.period = '0;
		req.slot = '0;
		rsp.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		directed_items();
		done = 0;
		while (done < RANDOM_ITEMS) begin
			if (done % 50 == 0)
				steady = ($urandom_range(0, 3) == 0);
			random_item(counted);
			if (counted)
				done++;
		end
		req.valid <= 1'b0;
		steady = 1'b0;
		while (board.expected_events.size() != 0)
			@(posedge clk);
		repeat (320) @(posedge clk);
		if (board.expected_events.size() != 0)
			board.report("expected results still outstanding");
		$display("covered %0d adds, %0d deletes, %0d ticks and %0d ignored items",
			board.adds, board.dels, board.ticks, board.ignored);
		$display("checked %0d results: %0d timer fires, %0d refusals on a full queue",
			board.checked, board.fires, board.refusals);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#30000000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ sorted_timer_queue_unit.f @@
+incdir+hw/rtl
hw/rtl/stq_pkg.sv
hw/rtl/stq_if.sv
hw/rtl/stq_mem.sv
hw/rtl/stq_ctrl.sv
hw/rtl/sorted_timer_queue_unit.sv
dv/sorted_timer_queue_unit_test.sv
